### design/eq_pkg.sv
// ============================================================================
// eq_pkg
// Shared types, widths and constants for the Euler-to-quaternion converter.
// ============================================================================
package eq_pkg;

    // Number of CORDIC micro-rotations per lane (12 to 24)
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_COUNT    = 24;

    // Pipeline depth: input stage, CORDIC stages, two multiply stages, output
    localparam int PIPE_STAGES = CORDIC_STAGES + 4;

    localparam int ANGLE_W = 16;   // Q3.12 input angle
    localparam int ZIN_W   = 34;   // half angle before range reduction
    localparam int Z_W     = 33;   // residual angle inside the CORDIC
    localparam int XY_W    = 33;   // CORDIC x/y working width
    localparam int CS_W    = 32;   // cosine / sine in Q1.30
    localparam int PROD_W  = 64;   // full product width
    localparam int TRI_W   = 18;   // one triple product in Q3.14
    localparam int SUM_W   = 19;   // sum of two triple products
    localparam int QUAT_W  = 16;   // Q1.14 result

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [CS_W-1:0]    cs_t;
    typedef logic signed [TRI_W-1:0]   tri_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [QUAT_W-1:0]  quat_t;

    localparam logic signed [ZIN_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZIN_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [XY_W-1:0]  GAIN_Q30    = 33'sd652032874;
    localparam logic signed [SUM_W-1:0] ONE_Q14     = 19'sd16384;

    // atan(2^-i) in Q1.30
    localparam logic signed [Z_W-1:0] ATAN_Q30 [ATAN_COUNT] = '{
        33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
        33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
        33'sd4194283,   33'sd2097149,   33'sd1048575,   33'sd524288,
        33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
        33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
        33'sd1024,      33'sd512,       33'sd256,       33'sd128
    };

    // Clamp a sum of two triple products to plus or minus one
    function automatic quat_t sat_q14(input sum_t v);
        sum_t c;
        begin
            c = v;
            if (v > ONE_Q14)
            begin
                c = ONE_Q14;
            end
            else if (v < -ONE_Q14)
            begin
                c = -ONE_Q14;
            end
            return c[QUAT_W-1:0];
        end
    endfunction

endpackage

### design/eq_angle_if.sv
// ============================================================================
// eq_angle_if
// Valid/ready channel carrying one yaw, pitch, roll triple per transfer.
// ============================================================================
interface eq_angle_if;
    import eq_pkg::*;

    logic   valid;
    logic   ready;
    angle_t yaw_angle;
    angle_t pitch_angle;
    angle_t roll_angle;

    modport source (output valid, output yaw_angle, output pitch_angle,
                    output roll_angle, input ready);
    modport sink   (input valid, input yaw_angle, input pitch_angle,
                    input roll_angle, output ready);
endinterface

// ============================================================================
// eq_quat_if
// Valid/ready channel carrying one quaternion per transfer.
// ============================================================================
interface eq_quat_if;
    import eq_pkg::*;

    logic  valid;
    logic  ready;
    quat_t quat_w;
    quat_t quat_x;
    quat_t quat_y;
    quat_t quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

### design/eq_cordic.sv
// ============================================================================
// eq_cordic
// Pipelined rotation-mode CORDIC giving cosine and sine of half an angle.
// ============================================================================
module eq_cordic (
    input  logic                          clk,
    input  logic [eq_pkg::CORDIC_STAGES:0] en,
    input  eq_pkg::angle_t                angle,
    output eq_pkg::cs_t                   cos_val,
    output eq_pkg::cs_t                   sin_val
);
    import eq_pkg::*;

    logic signed [XY_W-1:0] x_reg [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] y_reg [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]  z_reg [CORDIC_STAGES+1];
    logic                   flip_reg [CORDIC_STAGES+1];

    logic signed [ZIN_W-1:0] z_in;
    logic signed [ZIN_W-1:0] z_red;
    logic                    flip_next;
    logic signed [XY_W-1:0]  x_out;
    logic signed [XY_W-1:0]  y_out;

    // Half angle and fold into [-pi/2, pi/2]
    always_comb
    begin
        z_in      = signed'({angle[ANGLE_W-1], angle, 17'b0});
        z_red     = z_in;
        flip_next = 1'b0;
        if (z_in > HALF_PI_Q30)
        begin
            z_red     = z_in - PI_Q30;
            flip_next = 1'b1;
        end
        else if (z_in < -HALF_PI_Q30)
        begin
            z_red     = z_in + PI_Q30;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0]    <= GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_red[Z_W-1:0];
            flip_reg[0] <= flip_next;
        end
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en[i+1])
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][Z_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_Q30[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_Q30[i];
                end
            end
        end
    end

    // Undo the fold by negation
    always_comb
    begin
        x_out = flip_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
        y_out = flip_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
    end

    assign cos_val = cs_t'(x_out[CS_W-1:0]);
    assign sin_val = cs_t'(y_out[CS_W-1:0]);

endmodule

### design/eq_triple.sv
// ============================================================================
// eq_triple
// Two-stage rounded triple product a*b*c, Q1.30 inputs to Q3.14 result.
// ============================================================================
module eq_triple (
    input  logic        clk,
    input  logic [1:0]  en,
    input  eq_pkg::cs_t a,
    input  eq_pkg::cs_t b,
    input  eq_pkg::cs_t c,
    output eq_pkg::tri_t prod
);
    import eq_pkg::*;

    logic signed [PROD_W-1:0] ab_reg;
    cs_t                      c_reg;
    logic signed [PROD_W-1:0] abc_reg;
    logic signed [PROD_W-1:0] ab_shift;
    logic signed [PROD_W-1:0] abc_shift;
    cs_t                      ab_q30;

    // First product, with the Q1.30 rounding offset
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ab_reg <= PROD_W'(a) * PROD_W'(b) + (PROD_W'(1) <<< 29);
            c_reg  <= c;
        end
    end

    always_comb
    begin
        ab_shift = ab_reg >>> 30;
        ab_q30   = cs_t'(ab_shift[CS_W-1:0]);
    end

    // Second product, with the Q1.14 rounding offset
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            abc_reg <= PROD_W'(ab_q30) * PROD_W'(c_reg) + (PROD_W'(1) <<< 45);
        end
    end

    always_comb
    begin
        abc_shift = abc_reg >>> 46;
    end

    assign prod = tri_t'(abc_shift[TRI_W-1:0]);

endmodule

### design/euler_to_quaternion.sv
// ============================================================================
// euler_to_quaternion
// Converts yaw, pitch, roll (Q3.12 radians) into a unit quaternion (Q1.14).
// ============================================================================
// Usage:
//   angles : sink channel, one yaw/pitch/roll triple per transfer.
//   quat   : source channel, one quaternion w, x, y, z per transfer.
//   Every input transfer produces exactly one output transfer, in order.
// Pipeline: CORDIC_STAGES + 4 register stages (20 with 16 CORDIC stages): one
//   range-reduction stage, one stage per CORDIC micro-rotation, two multiplier
//   stages and the output register.
// Throughput: one triple per cycle while the receiver keeps quat.ready high; the
//   three CORDIC lanes and eight triple product units are fully pipelined.
// Stalls: each stage holds its item while the next stage is full and not
//   moving, so bubbles close up; a stalled receiver fills the pipeline and
//   then drops angles.ready. Nothing is lost or repeated.
// Reset: clears all stage valid bits; the data registers are not reset.
// ============================================================================
module euler_to_quaternion (
    input  logic        clk,
    input  logic        rst_n,
    eq_angle_if.sink    angles,
    eq_quat_if.source   quat
);
    import eq_pkg::*;

    localparam int M1 = CORDIC_STAGES + 1;
    localparam int M2 = CORDIC_STAGES + 2;
    localparam int OS = CORDIC_STAGES + 3;

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] en;

    cs_t  cy, sy, cp, sp, cr, sr;
    tri_t t [8];
    quat_t w_reg, x_reg, y_reg, z_reg;

    // Per-stage advance: a stage moves when empty or when its successor moves
    always_comb
    begin
        en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || quat.ready;
        for (int k = PIPE_STAGES-2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = angles.valid;
        end
        for (int k = 1; k < PIPE_STAGES; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign angles.ready = en[0];

    // Sine and cosine lanes
    eq_cordic u_cordic_yaw (
        .clk(clk), .en(en[CORDIC_STAGES:0]), .angle(angles.yaw_angle),
        .cos_val(cy), .sin_val(sy)
    );
    eq_cordic u_cordic_pitch (
        .clk(clk), .en(en[CORDIC_STAGES:0]), .angle(angles.pitch_angle),
        .cos_val(cp), .sin_val(sp)
    );
    eq_cordic u_cordic_roll (
        .clk(clk), .en(en[CORDIC_STAGES:0]), .angle(angles.roll_angle),
        .cos_val(cr), .sin_val(sr)
    );

    // Eight triple products
    eq_triple u_t0 (.clk(clk), .en(en[M2:M1]), .a(cy), .b(cp), .c(cr), .prod(t[0]));
    eq_triple u_t1 (.clk(clk), .en(en[M2:M1]), .a(sy), .b(sp), .c(sr), .prod(t[1]));
    eq_triple u_t2 (.clk(clk), .en(en[M2:M1]), .a(cy), .b(cp), .c(sr), .prod(t[2]));
    eq_triple u_t3 (.clk(clk), .en(en[M2:M1]), .a(sy), .b(sp), .c(cr), .prod(t[3]));
    eq_triple u_t4 (.clk(clk), .en(en[M2:M1]), .a(sy), .b(cp), .c(sr), .prod(t[4]));
    eq_triple u_t5 (.clk(clk), .en(en[M2:M1]), .a(cy), .b(sp), .c(cr), .prod(t[5]));
    eq_triple u_t6 (.clk(clk), .en(en[M2:M1]), .a(sy), .b(cp), .c(cr), .prod(t[6]));
    eq_triple u_t7 (.clk(clk), .en(en[M2:M1]), .a(cy), .b(sp), .c(sr), .prod(t[7]));

    // Sum, saturate and register the result
    always_ff @(posedge clk)
    begin
        if (en[OS])
        begin
            w_reg <= sat_q14(SUM_W'(t[0]) + SUM_W'(t[1]));
            x_reg <= sat_q14(SUM_W'(t[2]) - SUM_W'(t[3]));
            y_reg <= sat_q14(SUM_W'(t[4]) + SUM_W'(t[5]));
            z_reg <= sat_q14(SUM_W'(t[6]) - SUM_W'(t[7]));
        end
    end

    assign quat.valid  = valid_reg[OS];
    assign quat.quat_w = w_reg;
    assign quat.quat_x = x_reg;
    assign quat.quat_y = y_reg;
    assign quat.quat_z = z_reg;

endmodule

### sim/eq_scoreboard.sv
// ============================================================================
// eq_scoreboard
// Predicts the quaternion for each accepted angle triple and checks results.
// ============================================================================
package eq_scoreboard_pkg;
    import eq_pkg::*;

    typedef struct {
        quat_t w;
        quat_t x;
        quat_t y;
        quat_t z;
    } quat_exp_t;

    class quat_scoreboard;
        quat_exp_t pending[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // floor shift of a signed value
        static function longint fshift(longint v, int s);
            return v >>> s;
        endfunction

        // cosine and sine of half angle in Q1.30
        static function void half_cs(angle_t a, output longint c, output longint s);
            longint z;
            longint x;
            longint y;
            longint nx;
            bit     flip;
            z = longint'(a) * 131072;
            x = longint'(GAIN_Q30);
            y = 0;
            flip = 0;
            if (z > longint'(HALF_PI_Q30))
            begin
                z = z - longint'(PI_Q30);
                flip = 1;
            end
            else if (z < -longint'(HALF_PI_Q30))
            begin
                z = z + longint'(PI_Q30);
                flip = 1;
            end
            for (int i = 0; i < CORDIC_STAGES && i < ATAN_COUNT; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - fshift(y, i);
                    y = y + fshift(x, i);
                    z = z - longint'(ATAN_Q30[i]);
                end
                else
                begin
                    nx = x + fshift(y, i);
                    y = y - fshift(x, i);
                    z = z + longint'(ATAN_Q30[i]);
                end
                x = nx;
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            c = x;
            s = y;
        endfunction

        static function longint prod3(longint a, longint b, longint c);
            longint ab;
            ab = fshift(a * b + (64'sd1 <<< 29), 30);
            return fshift(ab * c + (64'sd1 <<< 45), 46);
        endfunction

        static function quat_t clamp(longint v);
            if (v > 16384) v = 16384;
            if (v < -16384) v = -16384;
            return quat_t'(v);
        endfunction

        // note an accepted angle triple
        function void note_angles(angle_t yaw, angle_t pitch, angle_t roll);
            longint cy, sy, cp, sp, cr, sr;
            quat_exp_t q;
            half_cs(yaw, cy, sy);
            half_cs(pitch, cp, sp);
            half_cs(roll, cr, sr);
            q.w = clamp(prod3(cy, cp, cr) + prod3(sy, sp, sr));
            q.x = clamp(prod3(cy, cp, sr) - prod3(sy, sp, cr));
            q.y = clamp(prod3(sy, cp, sr) + prod3(cy, sp, cr));
            q.z = clamp(prod3(sy, cp, cr) - prod3(cy, sp, sr));
            pending.push_back(q);
        endfunction

        // check one accepted quaternion transfer
        function void check_quat(quat_t w, quat_t x, quat_t y, quat_t z);
            quat_exp_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected quaternion %0d %0d %0d %0d", $realtime, w, x, y, z);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (w !== e.w)
            begin
                $display("%0t: quat_w expected %0d actual %0d", $realtime, e.w, w);
                errors++;
            end
            if (x !== e.x)
            begin
                $display("%0t: quat_x expected %0d actual %0d", $realtime, e.x, x);
                errors++;
            end
            if (y !== e.y)
            begin
                $display("%0t: quat_y expected %0d actual %0d", $realtime, e.y, y);
                errors++;
            end
            if (z !== e.z)
            begin
                $display("%0t: quat_z expected %0d actual %0d", $realtime, e.z, z);
                errors++;
            end
        endfunction
    endclass
endpackage

### sim/testbench.sv
// ============================================================================
// testbench
// Directed and random angle triples through the converter, with bursty
// input, a stalling receiver and a scoreboard checking every quaternion.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import eq_pkg::*;
    import eq_scoreboard_pkg::*;

    logic clk;
    logic rst_n;
    int   stall_mode;

    eq_angle_if angles ();
    eq_quat_if  quat ();

    quat_scoreboard sb;

    euler_to_quaternion u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .angles (angles.sink),
        .quat   (quat.source)
    );

    initial clk = 0;
    always #1 clk = ~clk;

    // pick an angle: mostly uniform, sometimes near the reduction boundary or at an extreme
    function automatic angle_t rand_angle();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return angle_t'($urandom_range(12860, 12876));
        else if (sel == 1)
            return angle_t'(-$urandom_range(12860, 12876));
        else if (sel == 2)
            return angle_t'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
        return angle_t'($urandom);
    endfunction

    // send one triple, holding valid until the transfer
    task automatic send_angles(angle_t yaw, angle_t pitch, angle_t roll);
        angles.valid       <= 1'b1;
        angles.yaw_angle   <= yaw;
        angles.pitch_angle <= pitch;
        angles.roll_angle  <= roll;
        @(posedge clk);
        while (!angles.ready)
            @(posedge clk);
        sb.note_angles(yaw, pitch, roll);
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            angles.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // receiver stall pattern and result checking
    always @(posedge clk)
    begin
        if (quat.valid && quat.ready)
            sb.check_quat(quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
        case (stall_mode)
            0: quat.ready <= 1'b1;
            1: quat.ready <= ($urandom_range(0, 3) != 0);
            default: quat.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
        if ($urandom_range(0, 99) == 0)
            stall_mode <= $urandom_range(0, 2);

    // stimulus
    initial
    begin
        angle_t dir[] = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff,
                          16'sd6434, -16'sd6434, 16'sd12868, -16'sd12868,
                          16'sd12867, -16'sd12867, 16'sd12869, -16'sd12869};
        int     gap;
        int     burst;
        sb = new();
        rst_n = 1'b0;
        angles.valid = 1'b0;
        angles.yaw_angle = '0;
        angles.pitch_angle = '0;
        angles.roll_angle = '0;
        quat.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes and range reduction boundaries on each lane
        foreach (dir[i])
            send_angles(dir[i], dir[(i + 3) % dir.size()], dir[(i + 7) % dir.size()]);
        send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_angles(16'sh8000, 16'sh8000, 16'sh8000);
        send_angles(16'sh5555, 16'shaaaa, 16'sh5555);
        send_angles(16'shaaaa, 16'sh5555, 16'shaaaa);
        idle_gap(3);
        // random bursts
        for (int n = 0; n < 1800; )
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++)
            begin
                send_angles(rand_angle(), rand_angle(), rand_angle());
                n++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            idle_gap(gap);
        end
        angles.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (CORDIC_STAGES + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end
endmodule

### filelist.f
design/eq_pkg.sv
design/eq_angle_if.sv
design/eq_cordic.sv
design/eq_triple.sv
design/euler_to_quaternion.sv
sim/eq_scoreboard.sv
sim/testbench.sv
